// ===== rtl/core/ranging_timing_budget_calc_core_defines.svh =====
// Assertion macros shared by the core
`ifndef RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH
`define RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH

`ifndef SYNTH
`define RTBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define RTBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define RTBC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RTBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/rtbc_pkg.sv =====
package rtbc_pkg;

  localparam logic [31:0] OVH_START = 32'd1910;
  localparam logic [31:0] OVH_END   = 32'd960;
  localparam logic [31:0] OVH_MSRC  = 32'd660;
  localparam logic [31:0] OVH_TCC   = 32'd590;
  localparam logic [31:0] OVH_DSS   = 32'd690;
  localparam logic [31:0] OVH_PRE   = 32'd660;
  localparam logic [31:0] OVH_FINAL = 32'd550;
  // 2304 * 1655
  localparam logic [21:0] MACRO_AB  = 22'd3813120;
  localparam logic [31:0] HALF_K    = 32'd500;
  localparam logic [9:0]  ONE_K     = 10'd1000;
  // floor(x / 1000) == (x * RECIP_K) >> RECIP_SH for any 32-bit x
  localparam logic [28:0] RECIP_K   = 29'h10624DD3;
  localparam int          RECIP_SH  = 38;
  localparam int          DIV_STEPS = 32;
  localparam logic [31:0] HIGH_MASK = 32'hFFFFFF00;

  typedef struct packed {
    logic [31:0] total;
    logic        fits;
    logic        wr;
    logic        pre;
    logic [15:0] pre_clk;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] num;
    logic [19:0] div;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] q;
    side_t       side;
  } enc_in_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] total;
    logic        fits;
    logic [15:0] code;
    logic        wr;
  } res_t;

  // quotient reaches 4294967, so 23 bits are kept
  function automatic logic [31:0] div_k(input logic [31:0] x);
    logic [60:0] p;
    p = x * RECIP_K;
    return {9'd0, p[RECIP_SH+22:RECIP_SH]};
  endfunction

  function automatic logic [4:0] bitlen16(input logic [15:0] x);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/rtbc_if.sv =====
interface rtbc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  step_enables;
  logic [7:0]  pre_period_code;
  logic [7:0]  final_period_code;
  logic [7:0]  short_step_timeout;
  logic [15:0] pre_timeout_code;
  logic [15:0] final_timeout_code;
  logic [31:0] requested_budget_us;

  modport source (output valid, step_enables, pre_period_code, final_period_code,
                  short_step_timeout, pre_timeout_code, final_timeout_code,
                  requested_budget_us, input ready);
  modport sink (input valid, step_enables, pre_period_code, final_period_code,
                short_step_timeout, pre_timeout_code, final_timeout_code,
                requested_budget_us, output ready);
endinterface

interface rtbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_budget_us;
  logic        budget_fits;
  logic [15:0] new_final_code;
  logic        final_write;

  modport source (output valid, current_budget_us, budget_fits, new_final_code,
                  final_write, input ready);
  modport sink (input valid, current_budget_us, budget_fits, new_final_code,
                final_write, output ready);
endinterface

// ===== rtl/core/rtbc_front.sv =====
module rtbc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [7:0]      step_enables,
  input  logic [7:0]      pre_period_code,
  input  logic [7:0]      final_period_code,
  input  logic [7:0]      short_step_timeout,
  input  logic [15:0]     pre_timeout_code,
  input  logic [15:0]     final_timeout_code,
  input  logic [31:0]     requested_budget_us,
  output rtbc_pkg::div_in_t dout
);
  import rtbc_pkg::*;

  typedef struct packed {
    logic tcc, dss, msrc, pre, fin;
  } flags_t;

  // stage 1: decode
  logic        v1;
  flags_t      f1;
  logic [31:0] mraw_pre1, mraw_fin1, req1;
  logic [8:0]  sclk1;
  logic [15:0] pclk1, fclk1;
  // stage 2: macro periods
  logic        v2;
  flags_t      f2;
  logic [19:0] mpre2, mfin2;
  logic [31:0] req2;
  logic [8:0]  sclk2;
  logic [15:0] pclk2, fclk2;
  // stage 3: clock products
  logic        v3;
  flags_t      f3;
  logic [31:0] sraw3, praw3, fraw3, req3;
  logic [19:0] mfin3;
  logic [15:0] pclk3;
  // stage 4: microseconds
  logic        v4;
  flags_t      f4;
  logic [31:0] su4, pu4, fu4, req4;
  logic [19:0] mfin4;
  logic [15:0] pclk4;
  // stage 5: base
  logic        v5;
  flags_t      f5;
  logic [31:0] base5, fu5, req5;
  logic [19:0] mfin5;
  logic [15:0] pclk5;

  logic [7:0]  pre_p, fin_p;
  logic [15:0] pdec, fdec;
  logic [31:0] base_next, used, num;

  function automatic logic [15:0] decode_to(input logic [15:0] code);
    logic [15:0] sh;
    sh = (code[15:8] >= 8'd16) ? 16'd0 : (16'(code[7:0]) << code[11:8]);
    return sh + 16'd1;
  endfunction

  always_comb begin
    pre_p = {pre_period_code[6:0] + 7'd1, 1'b0};
    fin_p = {final_period_code[6:0] + 7'd1, 1'b0};
    pdec  = decode_to(pre_timeout_code);
    fdec  = decode_to(final_timeout_code);
  end

  always_comb begin
    base_next = OVH_START + OVH_END;
    if (f4.tcc) base_next = base_next + su4 + OVH_TCC;
    if (f4.dss) base_next = base_next + {su4[30:0], 1'b0} + {OVH_DSS[30:0], 1'b0};
    else if (f4.msrc) base_next = base_next + su4 + OVH_MSRC;
    if (f4.pre) base_next = base_next + pu4 + OVH_PRE;
  end

  always_comb begin
    used = base5 + OVH_FINAL;
    num  = 32'((req5 - used) * ONE_K) + {13'd0, mfin5[19:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dout.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= '{tcc: step_enables[4], dss: step_enables[3], msrc: step_enables[2],
              pre: step_enables[6], fin: step_enables[7]};
      mraw_pre1 <= 32'(MACRO_AB * pre_p) + HALF_K;
      mraw_fin1 <= 32'(MACRO_AB * fin_p) + HALF_K;
      sclk1 <= {1'b0, short_step_timeout} + 9'd1;
      pclk1 <= pdec;
      fclk1 <= step_enables[6] ? fdec - pdec : fdec;
      req1  <= requested_budget_us;

      f2 <= f1;
      mpre2 <= 20'(div_k(mraw_pre1));
      mfin2 <= 20'(div_k(mraw_fin1));
      sclk2 <= sclk1;
      pclk2 <= pclk1;
      fclk2 <= fclk1;
      req2  <= req1;

      f3 <= f2;
      sraw3 <= 32'(sclk2 * mpre2) + HALF_K;
      praw3 <= 32'(pclk2 * mpre2) + HALF_K;
      fraw3 <= 32'(fclk2 * mfin2) + HALF_K;
      mfin3 <= mfin2;
      pclk3 <= pclk2;
      req3  <= req2;

      f4 <= f3;
      su4 <= div_k(sraw3);
      pu4 <= div_k(praw3);
      fu4 <= div_k(fraw3);
      mfin4 <= mfin3;
      pclk4 <= pclk3;
      req4  <= req3;

      f5 <= f4;
      base5 <= base_next;
      fu5 <= fu4;
      mfin5 <= mfin4;
      pclk5 <= pclk4;
      req5  <= req4;

      dout.num <= num;
      dout.div <= mfin5;
      dout.side.total <= f5.fin ? base5 + fu5 + OVH_FINAL : base5;
      dout.side.fits  <= !(f5.fin && (used > req5));
      dout.side.wr    <= f5.fin && !(used > req5);
      dout.side.pre   <= f5.pre;
      dout.side.pre_clk <= pclk5;
    end
  end

endmodule

// ===== rtl/core/rtbc_div.sv =====
module rtbc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  rtbc_pkg::div_in_t din,
  output rtbc_pkg::enc_in_t dout
);
  import rtbc_pkg::*;

  // one quotient bit per stage, restoring
  logic [DIV_STEPS-1:0] v;
  logic [31:0]          num [DIV_STEPS];
  logic [31:0]          q   [DIV_STEPS];
  logic [20:0]          rem [DIV_STEPS];
  logic [19:0]          dv  [DIV_STEPS];
  side_t                sd  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        v_in;
    logic [31:0] num_in, q_in;
    logic [20:0] rem_in, trial;
    logic [19:0] dv_in;
    side_t       sd_in;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in   = din.valid;
      assign num_in = din.num;
      assign q_in   = '0;
      assign rem_in = '0;
      assign dv_in  = din.div;
      assign sd_in  = din.side;
    end else begin : g_rest
      assign v_in   = v[k-1];
      assign num_in = num[k-1];
      assign q_in   = q[k-1];
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
      assign sd_in  = sd[k-1];
    end

    assign trial = {rem_in[19:0], num_in[31]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (adv) v[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        num[k] <= {num_in[30:0], 1'b0};
        q[k]   <= {q_in[30:0], ge};
        rem[k] <= ge ? trial - {1'b0, dv_in} : trial;
        dv[k]  <= dv_in;
        sd[k]  <= sd_in;
      end
    end
  end

  assign dout.valid = v[DIV_STEPS-1];
  assign dout.q     = q[DIV_STEPS-1];
  assign dout.side  = sd[DIV_STEPS-1];

endmodule

// ===== rtl/core/rtbc_enc.sv =====
module rtbc_enc (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  rtbc_pkg::enc_in_t din,
  output rtbc_pkg::res_t    res
);
  import rtbc_pkg::*;

  // stage a: add back pre-range clocks, bit length of each half
  logic        va;
  side_t       sda;
  logic [31:0] lsa;
  logic        zero_a, hi_nz_a;
  logic [4:0]  blh_a, bll_a;

  logic [31:0] clk_sum, ls;
  logic [5:0]  bl;
  logic [5:0]  ms;
  logic [31:0] shifted;
  logic [15:0] code;

  always_comb begin
    clk_sum = din.side.pre ? din.q + {16'd0, din.side.pre_clk} : din.q;
    ls = clk_sum - 32'd1;
  end

  always_comb begin
    bl = hi_nz_a ? 6'd16 + {1'b0, blh_a} : {1'b0, bll_a};
    ms = ((lsa & HIGH_MASK) != 32'd0) ? bl - 6'd8 : 6'd0;
    shifted = lsa >> ms;
    code = zero_a ? 16'd0 : {2'b00, ms, shifted[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      va <= din.valid;
      res.valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sda <= din.side;
      lsa <= ls;
      zero_a <= clk_sum == 32'd0;
      hi_nz_a <= ls[31:16] != 16'd0;
      blh_a <= bitlen16(ls[31:16]);
      bll_a <= bitlen16(ls[15:0]);

      res.total <= sda.total;
      res.fits  <= sda.fits;
      res.wr    <= sda.wr;
      res.code  <= sda.wr ? code : 16'd0;
    end
  end

endmodule

// ===== rtl/core/ranging_timing_budget_calc_core.sv =====
// Each accepted word passes through the front, the divider and the encoder to its result word.
// Throughput: one word per cycle while the output is not stalled; the 32-step restoring divider is fully pipelined.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all stage valid bits; payload is not reset.
`include "ranging_timing_budget_calc_core_defines.svh"
module ranging_timing_budget_calc_core (
  input logic        clk,
  input logic        rst,
  rtbc_in_if.sink    in_ch,
  rtbc_out_if.source out_ch
);
  import rtbc_pkg::*;

  logic    adv;
  div_in_t front_q;
  enc_in_t div_q;
  res_t    res;

  assign adv = !res.valid || out_ch.ready;
  assign in_ch.ready = adv;

  rtbc_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .in_valid            (in_ch.valid),
    .step_enables        (in_ch.step_enables),
    .pre_period_code     (in_ch.pre_period_code),
    .final_period_code   (in_ch.final_period_code),
    .short_step_timeout  (in_ch.short_step_timeout),
    .pre_timeout_code    (in_ch.pre_timeout_code),
    .final_timeout_code  (in_ch.final_timeout_code),
    .requested_budget_us (in_ch.requested_budget_us),
    .dout                (front_q)
  );

  rtbc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (front_q),
    .dout (div_q)
  );

  rtbc_enc u_enc (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .din (div_q),
    .res (res)
  );

  assign out_ch.valid             = res.valid;
  assign out_ch.current_budget_us = res.total;
  assign out_ch.budget_fits       = res.fits;
  assign out_ch.new_final_code    = res.code;
  assign out_ch.final_write       = res.wr;

  `RTBC_ASSERT_IMPL(a_write_needs_fit, clk, rst, res.valid && res.wr, res.fits)
  `RTBC_ASSERT_IMPL(a_no_write_no_code, clk, rst, res.valid && !res.wr, res.code == 16'd0)
  `RTBC_ASSERT_NEXT(a_stall_holds_pipe, clk, rst, res.valid && !out_ch.ready,
                    res.valid && $stable(div_q.valid) && $stable(front_q.valid))

endmodule
